>>> hw/rtl/lrs_pkg.sv
// shared constants and control types of the linear interpolation resampler
package lrs_pkg;

  localparam int MAX_RUN   = 64;
  localparam int RUN_W     = $clog2(MAX_RUN);
  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 18;
  localparam int PHASE_W   = 22;
  localparam int FRAC_BITS = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam int DIV_STAGES = PHASE_W;

  localparam logic [PHASE_W-1:0] ONE_Q16  = PHASE_W'(1 << FRAC_BITS);
  localparam logic [PHASE_W-1:0] STEP_MIN =
    PHASE_W'(((1 << FRAC_BITS) + MAX_RUN - 1) / MAX_RUN);
  localparam logic [PHASE_W-1:0] STEP_MAX = PHASE_W'(63 * (1 << FRAC_BITS));

  localparam logic [RATE_W-1:0] OUT_RATE_RESET = RATE_W'(44100);

  // register index codes, taken from paddr[2]
  localparam logic REG_SRC_RATE = 1'b0;
  localparam logic REG_OUT_RATE = 1'b1;

  typedef struct packed {
    logic take_bypass;
    logic take_prime;
    logic take_skip;
    logic take_run;
    logic emit;
  } lrs_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic phase_ge_one;
    logic emit_last;
    logic out_full;
  } lrs_stat_t;

  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] step;
  } lrs_step_t;

endpackage

>>> hw/rtl/lrs_step_div.sv
// pipelined restoring divider for the q16 step, one quotient bit per stage
module lrs_step_div import lrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RATE_W-1:0] src_rate_i,
  input  logic [RATE_W-1:0] out_rate_i,
  output logic              busy_o,
  output lrs_step_t         step_o
);

  localparam int SAT_SHIFT = PHASE_W - FRAC_BITS;

  typedef struct packed {
    logic               sat;
    logic [RATE_W-1:0]  rem;
    logic [PHASE_W-1:0] rest;
    logic [PHASE_W-1:0] quo;
    logic [RATE_W-1:0]  dvs;
  } div_stage_t;

  function automatic div_stage_t div_bit(div_stage_t s);
    div_stage_t      o;
    logic [RATE_W:0] t;
    o = s;
    t = {s.rem, s.rest[PHASE_W-1]};
    if (t >= {1'b0, s.dvs}) begin
      o.rem = RATE_W'(t - {1'b0, s.dvs});
      o.quo = {s.quo[PHASE_W-2:0], 1'b1};
    end else begin
      o.rem = t[RATE_W-1:0];
      o.quo = {s.quo[PHASE_W-2:0], 1'b0};
    end
    o.rest = {s.rest[PHASE_W-2:0], 1'b0};
    return o;
  endfunction

  div_stage_t                  head;
  div_stage_t                  st_q [DIV_STAGES];
  logic       [DIV_STAGES-1:0] valid_q;
  logic       [PHASE_W-1:0]    quo;

  // quotient of 2^22 or more saturates, as does a zero output rate
  always_comb begin
    head.sat  = (out_rate_i == '0) ||
                ({{SAT_SHIFT{1'b0}}, src_rate_i} >= {out_rate_i, {SAT_SHIFT{1'b0}}});
    head.rem  = RATE_W'(src_rate_i >> SAT_SHIFT);
    head.rest = PHASE_W'({src_rate_i, {FRAC_BITS{1'b0}}});
    head.quo  = '0;
    head.dvs  = out_rate_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DIV_STAGES-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= div_bit(head);
    for (int i = 1; i < DIV_STAGES; i++) begin
      st_q[i] <= div_bit(st_q[i-1]);
    end
  end

  assign quo          = st_q[DIV_STAGES-1].quo;
  assign busy_o       = |valid_q;
  assign step_o.valid = valid_q[DIV_STAGES-1];
  assign step_o.step  = (st_q[DIV_STAGES-1].sat || (quo > STEP_MAX)) ? STEP_MAX :
                        (quo < STEP_MIN) ? STEP_MIN : quo;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_o.valid |-> (step_o.step >= STEP_MIN) && (step_o.step <= STEP_MAX))
    else $error("step out of range");

endmodule

>>> hw/rtl/lrs_datapath.sv
// phase accumulator, sample history, interpolation and output register
module lrs_datapath import lrs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       new_stream_i,
  input  logic                       chunk_end_i,
  input  lrs_cmd_t                   cmd_i,
  input  lrs_step_t                  step_res_i,
  input  logic                       out_stall_i,
  output lrs_stat_t                  stat_o,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       last_of_run_o,
  output logic                       flush_mark_o
);

  logic                       have_prev_q;
  logic [PHASE_W-1:0]         phase_q;
  logic [PHASE_W-1:0]         step_q;
  logic [RUN_W-1:0]           n_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [SAMPLE_W-1:0] cur_q;
  logic                       cend_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_out_q;
  logic                       last_q;
  logic                       flush_q;

  logic [PHASE_W:0]           phase_sum;
  logic [PHASE_W-1:0]         phase_fin;
  logic                       emit_last;
  logic signed [SAMPLE_W:0]   delta;
  logic signed [SAMPLE_W:0]   ph_s;
  logic signed [2*SAMPLE_W+1:0] prod;
  logic signed [SAMPLE_W-1:0] lerp_val;
  logic                       commit;

  assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};
  assign emit_last = (phase_sum >= {1'b0, ONE_Q16}) || (n_q == RUN_W'(MAX_RUN - 1));
  // phase after the last result of an input
  assign phase_fin = (phase_sum >= {1'b0, ONE_Q16}) ?
                     PHASE_W'(phase_sum - {1'b0, ONE_Q16}) : '0;

  // floor(delta * phase / 65536), result kept modulo 2^16
  assign delta    = {cur_q[SAMPLE_W-1], cur_q} - {prev_q[SAMPLE_W-1], prev_q};
  assign ph_s     = {1'b0, phase_q[FRAC_BITS-1:0]};
  assign prod     = delta * ph_s;
  assign lerp_val = prev_q + prod[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];

  assign commit = step_res_i.valid && (step_res_i.step != step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      step_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        step_q      <= step_res_i.step;
        phase_q     <= '0;
        have_prev_q <= 1'b0;
      end
      if ((cmd_i.take_bypass || cmd_i.take_prime) && new_stream_i) begin
        phase_q <= '0;
      end
      if (cmd_i.take_bypass && new_stream_i) begin
        have_prev_q <= 1'b0;
      end
      if (cmd_i.take_prime) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.take_skip) begin
        phase_q <= phase_q - ONE_Q16;
      end
      if (cmd_i.take_run) begin
        n_q <= '0;
      end
      if (cmd_i.emit) begin
        n_q     <= n_q + RUN_W'(1);
        phase_q <= emit_last ? phase_fin : phase_sum[PHASE_W-1:0];
      end
      if (cmd_i.take_bypass || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_prime || cmd_i.take_skip) begin
      prev_q <= sample_in_i;
    end
    if (cmd_i.take_run) begin
      cur_q  <= sample_in_i;
      cend_q <= chunk_end_i;
    end
    if (cmd_i.emit && emit_last) begin
      prev_q <= cur_q;
    end
    if (cmd_i.take_bypass) begin
      sample_out_q <= sample_in_i;
      last_q       <= 1'b1;
      flush_q      <= chunk_end_i;
    end else if (cmd_i.emit) begin
      sample_out_q <= lerp_val;
      last_q       <= emit_last;
      flush_q      <= emit_last && cend_q;
    end
  end

  assign stat_o.have_prev    = have_prev_q && !new_stream_i;
  assign stat_o.phase_ge_one = phase_q >= ONE_Q16;
  assign stat_o.emit_last    = emit_last;
  assign stat_o.out_full     = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_out_q;
  assign last_of_run_o = last_q;
  assign flush_mark_o  = flush_q;

  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (phase_q < ONE_Q16) && have_prev_q)
    else $error("interpolation outside the unit interval");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_res_i.valid |-> !(cmd_i.take_bypass || cmd_i.take_prime ||
                           cmd_i.take_skip || cmd_i.take_run || cmd_i.emit))
    else $error("step update during a transaction");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || !out_stall_i)
    else $error("output register overwritten");

endmodule

>>> hw/rtl/lrs_ctrl.sv
// controller: input acceptance and the per-result sequencing loop
module lrs_ctrl import lrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_stall_i,
  input  logic      bypass_i,
  input  logic      cfg_busy_i,
  input  lrs_stat_t stat_i,
  output logic      in_stall_o,
  output lrs_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q;
  logic state_d;
  logic accept;
  logic can_load;

  assign in_stall_o = (state_q != ST_IDLE) || cfg_busy_i || (bypass_i && stat_i.out_full);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_load   = !stat_i.out_full || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (bypass_i) begin
            cmd_o.take_bypass = 1'b1;
          end else if (!stat_i.have_prev) begin
            cmd_o.take_prime = 1'b1;
          end else if (stat_i.phase_ge_one) begin
            cmd_o.take_skip = 1'b1;
          end else begin
            cmd_o.take_run = 1'b1;
            state_d        = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (can_load) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/linear_interp_resampler_unit.sv
// Linear interpolation resampler top level: apb registers, step divider, controller, datapath.
// Order: a pass-through result is registered at its input transaction; an interpolated one by
// the first emit after the load and the rest one per cycle while the output does not stall. An
// interpolating input gives N results (N up to 64, one lerp multiply each) and holds off input
// until its last. A register write stalls input in setup, access and the 22-stage step divider.
// Reset: source rate 0 (bypass), output rate 44100, step 0, phase cleared, history marked empty.
module linear_interp_resampler_unit import lrs_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       new_stream_i,
  input  logic                       chunk_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       last_of_run_o,
  output logic                       flush_mark_o
);

  logic [RATE_W-1:0] src_rate_q;
  logic [RATE_W-1:0] src_rate_d;
  logic [RATE_W-1:0] out_rate_q;
  logic [RATE_W-1:0] out_rate_d;
  logic              wr_en;
  logic              div_busy;
  logic              bypass;
  lrs_step_t         step_res;
  lrs_cmd_t          cmd;
  lrs_stat_t         stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    src_rate_d = src_rate_q;
    out_rate_d = out_rate_q;
    if (wr_en) begin
      case (paddr[2])
        REG_SRC_RATE: src_rate_d = pwdata[RATE_W-1:0];
        REG_OUT_RATE: out_rate_d = pwdata[RATE_W-1:0];
        default:      src_rate_d = src_rate_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q <= '0;
      out_rate_q <= OUT_RATE_RESET;
    end else begin
      src_rate_q <= src_rate_d;
      out_rate_q <= out_rate_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SRC_RATE: prdata = DATA_W'(src_rate_q);
      REG_OUT_RATE: prdata = DATA_W'(out_rate_q);
      default:      prdata = '0;
    endcase
  end

  assign bypass = (src_rate_q == '0) || (src_rate_q == out_rate_q);

  lrs_step_div u_step_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (wr_en),
    .src_rate_i (src_rate_d),
    .out_rate_i (out_rate_d),
    .busy_o     (div_busy),
    .step_o     (step_res)
  );

  lrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .bypass_i    (bypass),
    .cfg_busy_i  (div_busy || psel),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  lrs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_in_i   (sample_in_i),
    .new_stream_i  (new_stream_i),
    .chunk_end_i   (chunk_end_i),
    .cmd_i         (cmd),
    .step_res_i    (step_res),
    .out_stall_i   (out_stall_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .sample_out_o  (sample_out_o),
    .last_of_run_o (last_of_run_o),
    .flush_mark_o  (flush_mark_o)
  );

endmodule
